// ===== hw/rtl/wrr_pkg.sv =====
package wrr_pkg;

  localparam int DEF_MAX_TASKS     = 16;
  localparam int DEF_PRIORITY_BITS = 8;

  localparam int ID_W     = 4;
  localparam int SLICE_W  = 8;
  localparam int OP_W     = 2;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_TICK   = 2'd0;
  localparam logic [OP_W-1:0] OP_ADD    = 2'd1;
  localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

  localparam logic [STATUS_W-1:0] ST_OK         = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NO_TASK    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL       = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_QUEUED = 2'd3;

  typedef enum logic [1:0] {
    S_IDLE,
    S_WALK,
    S_TAIL,
    S_DONE
  } state_t;

  // per-cell control from the sequencer
  typedef struct packed {
    logic shift;
    logic load;
  } cell_ctl_t;

endpackage

// ===== hw/rtl/wrr_cell.sv =====
module wrr_cell #(
  parameter int W = wrr_pkg::ID_W + wrr_pkg::DEF_PRIORITY_BITS
) (
  input  logic               clk,
  input  wrr_pkg::cell_ctl_t ctl,
  input  logic [W-1:0]       nbr,
  input  logic [W-1:0]       bus,
  output logic [W-1:0]       word
);

  // a tail load wins over the shift from the neighbour
  always_ff @(posedge clk) begin
    if (ctl.load) begin
      word <= bus;
    end else if (ctl.shift) begin
      word <= nbr;
    end
  end

endmodule

// ===== hw/rtl/weighted_round_robin_task_scheduler.sv =====
// Weighted round-robin task scheduler. The run queue is a row of MAX_TASKS cells, each holding
// one task id and its slice length; the head cell is the next task to run. Add, remove and a
// tick that takes the slice away from a current task walk the queue once: each cycle the head
// entry leaves cell 0, every cell takes its neighbour's entry, and the head entry is either
// written back at the tail or dropped. The result is registered in S_DONE, after the walk in
// S_WALK, one entry at a time through the head cell, and the tail step in S_TAIL. Unused op
// codes, ticks that keep the current slice and ticks with no current task skip the walk. The
// next word is accepted once the result is registered, even while that result still waits
// for out_ready. A result still waiting for out_ready holds the following word in S_DONE
// until the output register is free. One result word is given for every input word.
module weighted_round_robin_task_scheduler #(
  parameter int MAX_TASKS     = wrr_pkg::DEF_MAX_TASKS,
  parameter int PRIORITY_BITS = wrr_pkg::DEF_PRIORITY_BITS
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [wrr_pkg::OP_W-1:0]     op,
  input  logic                         yield_now,
  input  logic                         cur_runnable,
  input  logic [wrr_pkg::ID_W-1:0]     task_id,
  input  logic [wrr_pkg::SLICE_W-1:0]  priority_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [wrr_pkg::ID_W-1:0]     run_task,
  output logic                         new_slice,
  output logic [wrr_pkg::STATUS_W-1:0] status
);

  import wrr_pkg::*;

  localparam int PW    = (PRIORITY_BITS < SLICE_W) ? PRIORITY_BITS : SLICE_W;
  localparam int W     = ID_W + PW;
  localparam int IDX_W = $clog2(MAX_TASKS);
  localparam int LEN_W = $clog2(MAX_TASKS + 1);

  state_t state, state_next;

  logic [OP_W-1:0]     op_q;
  logic                run_q;
  logic [ID_W-1:0]     id_q;
  logic [PW-1:0]       prio_q;
  logic [ID_W-1:0]     mid;
  logic                match_en;
  logic                found;
  logic [PW-1:0]       hold_prio;
  logic                rs_q;
  logic [STATUS_W-1:0] st_q;
  logic [LEN_W-1:0]    cnt;

  logic [LEN_W-1:0]    len;
  logic [ID_W-1:0]     cur_task;
  logic                cur_valid;
  logic [SLICE_W-1:0]  slice_left;

  logic [W-1:0]        cw  [MAX_TASKS];
  logic [W-1:0]        nbr [MAX_TASKS];
  cell_ctl_t           ctl [MAX_TASKS];

  logic [W-1:0]        bus;
  logic                shift_en;
  logic                load_en;
  logic [IDX_W-1:0]    ptr;

  logic [ID_W-1:0]     head_id;
  logic [PW-1:0]       head_prio;
  logic [LEN_W-1:0]    len_m1;
  logic [SLICE_W-1:0]  slice_dec;
  logic                accept;
  logic                walking;
  logic                hit;
  logic                drop_mode;
  logic                resched_now;
  logic                app_tick;
  logic                app_add;
  logic                out_load;

  logic [ID_W-1:0]     cur_task_next;
  logic                cur_valid_next;
  logic [SLICE_W-1:0]  slice_left_next;
  logic                fresh;
  logic [STATUS_W-1:0] st_out;

  // cell row
  for (genvar k = 0; k < MAX_TASKS; k++) begin : g_cell
    if (k == MAX_TASKS - 1) begin : g_last
      assign nbr[k] = bus;
    end else begin : g_mid
      assign nbr[k] = cw[k+1];
    end
    assign ctl[k].shift = shift_en;
    assign ctl[k].load  = load_en && (ptr == IDX_W'(k));
    wrr_cell #(.W(W)) u_cell (
      .clk  (clk),
      .ctl  (ctl[k]),
      .nbr  (nbr[k]),
      .bus  (bus),
      .word (cw[k])
    );
  end

  assign head_id     = cw[0][W-1:PW];
  assign head_prio   = cw[0][PW-1:0];
  assign len_m1      = len - LEN_W'(1);
  assign slice_dec   = slice_left - SLICE_W'(1);
  assign in_ready    = (state == S_IDLE);
  assign accept      = in_valid && in_ready;
  assign walking     = (state == S_WALK) && (cnt != '0);
  assign hit         = match_en && (head_id == mid);
  assign drop_mode   = (op_q != OP_ADD);
  assign resched_now = yield_now || (slice_dec == '0) || !cur_valid || !cur_runnable;
  assign app_tick    = (op_q == OP_TICK) && rs_q && found && run_q;
  assign app_add     = (op_q == OP_ADD) && !found && (len != LEN_W'(MAX_TASKS));
  assign out_load    = (state == S_DONE) && (!out_valid || out_ready);

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: if (accept) state_next = S_WALK;
      S_WALK: if (cnt == '0) state_next = S_TAIL;
      S_TAIL: state_next = S_DONE;
      S_DONE: if (out_load) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    shift_en = 1'b0;
    load_en  = 1'b0;
    ptr      = len_m1[IDX_W-1:0];
    bus      = cw[0];
    unique case (state)
      S_WALK: begin
        if (cnt != '0) begin
          // head leaves cell 0; kept words go back in at the tail
          shift_en = 1'b1;
          load_en  = !(hit && drop_mode);
          bus      = hit ? {head_id, prio_q} : cw[0];
          ptr      = len_m1[IDX_W-1:0];
        end
      end
      S_TAIL: begin
        load_en = app_tick || app_add;
        bus     = app_tick ? {cur_task, hold_prio} : {id_q, prio_q};
        ptr     = len[IDX_W-1:0];
      end
      default: ;
    endcase
  end

  // choice of the running task once the queue has settled
  always_comb begin
    cur_task_next   = cur_task;
    cur_valid_next  = cur_valid;
    slice_left_next = slice_left;
    fresh           = 1'b0;
    st_out          = st_q;
    if ((op_q == OP_TICK) && rs_q) begin
      if (len == '0) begin
        cur_task_next  = '0;
        cur_valid_next = 1'b0;
        st_out         = ST_NO_TASK;
      end else begin
        cur_task_next   = head_id;
        cur_valid_next  = 1'b1;
        slice_left_next = (head_prio == '0) ? SLICE_W'(1) : SLICE_W'(head_prio);
        fresh           = 1'b1;
      end
    end else if ((op_q == OP_REMOVE) && found && cur_valid && (cur_task == id_q)) begin
      cur_task_next  = '0;
      cur_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      out_valid  <= 1'b0;
      len        <= '0;
      cur_task   <= '0;
      cur_valid  <= 1'b0;
      slice_left <= '0;
    end else begin
      state <= state_next;
      if (accept && (op == OP_TICK)) begin
        slice_left <= slice_dec;
      end
      if (walking && hit && drop_mode) begin
        len <= len_m1;
      end
      if ((state == S_TAIL) && load_en) begin
        len <= len + LEN_W'(1);
      end
      if (out_load) begin
        cur_task   <= cur_task_next;
        cur_valid  <= cur_valid_next;
        slice_left <= slice_left_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_q   <= op;
      run_q  <= cur_runnable;
      id_q   <= task_id;
      prio_q <= priority_req[PW-1:0];
      found  <= 1'b0;
      st_q   <= ST_OK;
      unique case (op) inside
        OP_TICK: begin
          rs_q     <= resched_now;
          match_en <= cur_valid;
          mid      <= cur_task;
          cnt      <= (resched_now && cur_valid) ? len : '0;
        end
        OP_ADD, OP_REMOVE: begin
          rs_q     <= 1'b0;
          match_en <= 1'b1;
          mid      <= task_id;
          cnt      <= len;
        end
        default: begin
          rs_q     <= 1'b0;
          match_en <= 1'b0;
          mid      <= task_id;
          cnt      <= '0;
        end
      endcase
    end
    if (walking) begin
      cnt <= cnt - LEN_W'(1);
      if (hit) begin
        found <= 1'b1;
      end
      if (hit && drop_mode) begin
        hold_prio <= head_prio;
      end
    end
    if (state == S_TAIL) begin
      if ((op_q == OP_ADD) && !found && (len == LEN_W'(MAX_TASKS))) begin
        st_q <= ST_FULL;
      end else if ((op_q == OP_REMOVE) && !found) begin
        st_q <= ST_NOT_QUEUED;
      end
    end
    if (out_load) begin
      run_task  <= cur_valid_next ? cur_task_next : '0;
      new_slice <= fresh;
      status    <= st_out;
    end
  end

`ifndef SYNTHESIS
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    len <= LEN_W'(MAX_TASKS))
    else $error("run queue length beyond capacity");

  a_no_cur_zero: assert property (@(posedge clk) disable iff (rst)
    !cur_valid |-> (cur_task == '0))
    else $error("stale task id with no current task");

  a_walk_cnt: assert property (@(posedge clk) disable iff (rst)
    (state == S_WALK) |-> (cnt <= len))
    else $error("walk count runs past the queue");

  a_fresh_slice: assert property (@(posedge clk) disable iff (rst)
    (out_load && fresh) |=> (cur_valid && (slice_left != '0)))
    else $error("new slice taken with no task or empty slice");
`endif

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench;
  import wrr_pkg::*;

  localparam int QUEUE_SLOTS = DEF_MAX_TASKS;
  localparam int ID_COUNT    = 16;
  localparam int RAND_WORDS  = 1650;
  localparam int PHASE_LEN   = 150;
  localparam int CYCLE_LIMIT = 400000;
  localparam int DRAIN_WAIT  = QUEUE_SLOTS + 8;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [ID_W-1:0]     run_task;
    logic                new_slice;
    logic [STATUS_W-1:0] status;
  } sched_word_t;

  typedef struct packed {
    logic [OP_W-1:0]    op;
    logic               yld;
    logic               rn;
    logic [ID_W-1:0]    id;
    logic [SLICE_W-1:0] pr;
    logic               typed;
    sched_word_t        want;
  } dir_row_t;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  logic [OP_W-1:0]     op = OP_TICK;
  logic                yield_now = 1'b0;
  logic                cur_runnable = 1'b0;
  logic [ID_W-1:0]     task_id = '0;
  logic [SLICE_W-1:0]  priority_req = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  logic [ID_W-1:0]     run_task;
  logic                new_slice;
  logic [STATUS_W-1:0] status;

  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int error_count    = 0;
  int cycle_count    = 0;

  sched_word_t pending_words[$];

  // shadow of the scheduler state
  logic [ID_W-1:0]    rq_ids [QUEUE_SLOTS];
  logic [SLICE_W-1:0] prio_tab [ID_COUNT];
  int                 rq_len = 0;
  logic [ID_W-1:0]    cur_id = '0;
  logic               cur_on = 1'b0;
  logic [SLICE_W-1:0] slice_cnt = '0;

  // directed words; typed rows carry the obvious answer
  dir_row_t dir_tab [20] = '{
    '{OP_TICK,   1'b0, 1'b1, 4'd0,  8'd0,   1'b1, '{4'd0,  1'b0, ST_NO_TASK}},
    '{OP_REMOVE, 1'b0, 1'b0, 4'd5,  8'd0,   1'b1, '{4'd0,  1'b0, ST_NOT_QUEUED}},
    '{OP_UNUSED, 1'b0, 1'b0, 4'd0,  8'd0,   1'b1, '{4'd0,  1'b0, ST_OK}},
    '{OP_ADD,    1'b0, 1'b0, 4'd15, 8'd255, 1'b1, '{4'd0,  1'b0, ST_OK}},
    '{OP_ADD,    1'b0, 1'b0, 4'd0,  8'd0,   1'b1, '{4'd0,  1'b0, ST_OK}},
    '{OP_ADD,    1'b0, 1'b0, 4'd7,  8'd2,   1'b1, '{4'd0,  1'b0, ST_OK}},
    '{OP_TICK,   1'b0, 1'b1, 4'd0,  8'd0,   1'b1, '{4'd15, 1'b1, ST_OK}},
    '{OP_TICK,   1'b0, 1'b1, 4'd0,  8'd0,   1'b1, '{4'd15, 1'b0, ST_OK}},
    '{OP_TICK,   1'b1, 1'b1, 4'd0,  8'd0,   1'b1, '{4'd0,  1'b1, ST_OK}},
    '{OP_TICK,   1'b0, 1'b1, 4'd0,  8'd0,   1'b1, '{4'd7,  1'b1, ST_OK}},
    '{OP_ADD,    1'b0, 1'b0, 4'd7,  8'd1,   1'b0, '0},
    '{OP_TICK,   1'b0, 1'b0, 4'd0,  8'd0,   1'b1, '{4'd15, 1'b1, ST_OK}},
    '{OP_ADD,    1'b0, 1'b0, 4'd3,  8'd128, 1'b0, '0},
    '{OP_REMOVE, 1'b0, 1'b0, 4'd15, 8'd0,   1'b1, '{4'd0,  1'b0, ST_OK}},
    '{OP_TICK,   1'b1, 1'b1, 4'd0,  8'd0,   1'b0, '0},
    '{OP_REMOVE, 1'b0, 1'b0, 4'd3,  8'd0,   1'b0, '0},
    '{OP_TICK,   1'b0, 1'b1, 4'd0,  8'd0,   1'b0, '0},
    '{OP_REMOVE, 1'b0, 1'b0, 4'd0,  8'd0,   1'b1, '{4'd0,  1'b0, ST_OK}},
    '{OP_TICK,   1'b1, 1'b0, 4'd0,  8'd0,   1'b1, '{4'd0,  1'b0, ST_NO_TASK}},
    '{OP_UNUSED, 1'b1, 1'b1, 4'd15, 8'd255, 1'b1, '{4'd0,  1'b0, ST_OK}}
  };

  weighted_round_robin_task_scheduler DUT (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .op           (op),
    .yield_now    (yield_now),
    .cur_runnable (cur_runnable),
    .task_id      (task_id),
    .priority_req (priority_req),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .run_task     (run_task),
    .new_slice    (new_slice),
    .status       (status)
  );

  always #5 clk = ~clk;

  function automatic int queue_pos(logic [ID_W-1:0] id);
    for (int k = 0; k < rq_len; k++) begin
      if (rq_ids[k] == id) return k;
    end
    return -1;
  endfunction

  function automatic void queue_drop(int pos);
    for (int k = pos; k + 1 < rq_len; k++) rq_ids[k] = rq_ids[k + 1];
    if (rq_len > 0) rq_len--;
  endfunction

  function automatic logic queue_append(logic [ID_W-1:0] id);
    if (rq_len >= QUEUE_SLOTS) return 1'b0;
    rq_ids[rq_len] = id;
    rq_len++;
    return 1'b1;
  endfunction

  // one word through the shadow scheduler, returning the result it must give
  function automatic sched_word_t schedule_step(logic [OP_W-1:0] w_op, logic w_yield,
                                                logic w_run, logic [ID_W-1:0] w_id,
                                                logic [SLICE_W-1:0] w_prio);
    sched_word_t res;
    int          pos;
    res = '{run_task: '0, new_slice: 1'b0, status: ST_OK};
    case (w_op)
      OP_TICK: begin
        slice_cnt = slice_cnt - 8'd1;
        if (w_yield || slice_cnt == 0 || !cur_on || !w_run) begin
          if (cur_on) begin
            pos = queue_pos(cur_id);
            if (pos >= 0) begin
              queue_drop(pos);
              if (w_run) void'(queue_append(cur_id));
            end
          end
          if (rq_len == 0) begin
            cur_on = 1'b0;
            cur_id = '0;
            res.status = ST_NO_TASK;
          end else begin
            cur_id    = rq_ids[0];
            cur_on    = 1'b1;
            slice_cnt = (prio_tab[cur_id] == 0) ? 8'd1 : prio_tab[cur_id];
            res.new_slice = 1'b1;
          end
        end
      end
      OP_ADD: begin
        if (queue_pos(w_id) >= 0 || queue_append(w_id)) prio_tab[w_id] = w_prio;
        else res.status = ST_FULL;
      end
      OP_REMOVE: begin
        pos = queue_pos(w_id);
        if (pos < 0) begin
          res.status = ST_NOT_QUEUED;
        end else begin
          queue_drop(pos);
          if (cur_on && cur_id == w_id) begin
            cur_on = 1'b0;
            cur_id = '0;
          end
        end
      end
      default: ;
    endcase
    res.run_task = cur_on ? cur_id : '0;
    return res;
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", what, got, want);
    error_count++;
  endtask

  // present one word, wait for it to be taken, note what it must produce
  task automatic drive_word(logic [OP_W-1:0] w_op, logic w_yield, logic w_run,
                            logic [ID_W-1:0] w_id, logic [SLICE_W-1:0] w_prio,
                            logic typed, sched_word_t want);
    sched_word_t pred;
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    op           <= w_op;
    yield_now    <= w_yield;
    cur_runnable <= w_run;
    task_id      <= w_id;
    priority_req <= w_prio;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pred = schedule_step(w_op, w_yield, w_run, w_id, w_prio);
    pending_words.push_back(typed ? want : pred);
    @(negedge clk);
  endtask

  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    sched_word_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_words.size() == 0) begin
        $display("result word with nothing expected: run_task %0d new_slice %0d status %0d",
                 run_task, new_slice, status);
        error_count++;
      end else begin
        want = pending_words.pop_front();
        if (run_task !== want.run_task)
          report_mismatch("run_task", int'(run_task), int'(want.run_task));
        if (new_slice !== want.new_slice)
          report_mismatch("new_slice", int'(new_slice), int'(want.new_slice));
        if (status !== want.status)
          report_mismatch("status", int'(status), int'(want.status));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", pending_words.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    logic [OP_W-1:0]    r_op;
    logic               r_yield;
    logic               r_run;
    logic [ID_W-1:0]    r_id;
    logic [SLICE_W-1:0] r_prio;
    int                 sel;
    foreach (prio_tab[k]) prio_tab[k] = '0;
    foreach (rq_ids[k]) rq_ids[k] = '0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[k]) begin
      drive_word(dir_tab[k].op, dir_tab[k].yld, dir_tab[k].rn, dir_tab[k].id,
                 dir_tab[k].pr, dir_tab[k].typed, dir_tab[k].want);
    end

    for (int n = 0; n < RAND_WORDS; n++) begin
      case ((n / PHASE_LEN) % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 76; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 76; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      sel = $urandom_range(0, 99);
      if (sel < 40) r_op = OP_TICK;
      else if (sel < 75) r_op = OP_ADD;
      else if (sel < 95) r_op = OP_REMOVE;
      else r_op = OP_UNUSED;
      r_yield = ($urandom_range(0, 3) == 0);
      r_run   = ($urandom_range(0, 6) != 0);
      r_id    = ID_W'($urandom_range(0, ID_COUNT - 1));
      // mostly short slices so that expiry comes often
      r_prio  = ($urandom_range(0, 9) == 0) ? SLICE_W'($urandom_range(0, 255))
                                            : SLICE_W'($urandom_range(0, 5));
      drive_word(r_op, r_yield, r_run, r_id, r_prio, 1'b0, '0);
    end
    in_valid <= 1'b0;

    while (pending_words.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (error_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
